// File: design/tsew_pkg.sv
// ----------------------------------------------------------------------------
// tsew_pkg
// shared types, constants and helpers of the scanline edge walker
// ----------------------------------------------------------------------------
`default_nettype none

package tsew_pkg;

	localparam int COORD_FRAC_BITS = 4;
	localparam int SLOPE_FRAC_BITS = 16;
	localparam int GRAD_ONE        = 65536;
	localparam int DIV_BITS        = 32 + SLOPE_FRAC_BITS;
	localparam int DIV_CNT_W       = $clog2(DIV_BITS + 1);

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_NEAR   = 2'd2;

	localparam logic [1:0] EDGE_AB = 2'd0;
	localparam logic [1:0] EDGE_AC = 2'd1;
	localparam logic [1:0] EDGE_BC = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_AREA,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                start;
		logic [DIV_BITS-1:0] dividend;
		logic [16:0]         divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [DIV_BITS-1:0] quotient;
	} div_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		begin
			if (v > 34'sh0_7FFF_FFFF) begin
				r = 32'sh7FFF_FFFF;
			end else if (v < -34'sh0_8000_0000) begin
				r = 32'sh8000_0000;
			end else begin
				r = v[31:0];
			end
			return r;
		end
	endfunction

	function automatic logic signed [12:0] trunc_x(input logic signed [31:0] v);
		logic [31:0] mag;
		logic [31:0] w;
		logic signed [12:0] r;
		begin
			mag = v[31] ? 32'(-v) : 32'(v);
			w = mag >> SLOPE_FRAC_BITS;
			if (w > 32'd4096) begin
				r = v[31] ? -13'sd4096 : 13'sd4095;
			end else if (w == 32'd4096) begin
				r = v[31] ? -13'sd4096 : 13'sd4095;
			end else begin
				r = v[31] ? 13'(-$signed({1'b0, w[11:0]})) : $signed({1'b0, w[11:0]});
			end
			return r;
		end
	endfunction

endpackage

`default_nettype wire

// File: design/tsew_divider.sv
// ----------------------------------------------------------------------------
// tsew_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tsew_divider (
	input  wire                     clk,
	input  wire                     arst_n,
	input  tsew_pkg::div_req_t      req,
	output tsew_pkg::div_rsp_t      rsp
);
	import tsew_pkg::*;

	logic [DIV_BITS-1:0]  quo_q;
	logic [16:0]          rem_q;
	logic [16:0]          den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [17:0]          shifted;
	logic [17:0]          diff;

	assign shifted = {rem_q, quo_q[DIV_BITS-1]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[17]) begin
				rem_q <= diff[16:0];
				quo_q <= {quo_q[DIV_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted[16:0];
				quo_q <= {quo_q[DIV_BITS-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

// File: design/triangle_scanline_edge_walker.sv
// ----------------------------------------------------------------------------
// triangle_scanline_edge_walker
// loads a triangle, then hands out one span per step transfer
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | func, vertex x/y/z
//  out     | out_valid/out_stall| span fields
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// a step is accepted, then its result sits in the output register
// a load keeps the input stalled after its transfer: six divisions (start,
// 48 quotient bits, done) through one shared bit-serial divider, then the
// area products in ST_AREA and the walk setup in ST_FINISH; a rejected
// load leaves the block idle
// reset returns control state, configuration and outputs to their reset values
// input stalls while busy or while a result waits in the output register
`default_nettype none

module triangle_scanline_edge_walker (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire  [1:0]        cfg_index,
	input  wire  [15:0]       cfg_data,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire               func,
	input  wire  [15:0]       ax,
	input  wire  [15:0]       ay,
	input  wire signed [15:0] az,
	input  wire  [15:0]       bx,
	input  wire  [15:0]       by_coord,
	input  wire signed [15:0] bz,
	input  wire  [15:0]       cx,
	input  wire  [15:0]       cy,
	input  wire signed [15:0] cz,
	output logic              out_valid,
	input  wire               out_stall,
	output logic              span_valid,
	output logic [11:0]       row,
	output logic signed [12:0] left_x,
	output logic signed [12:0] right_x,
	output logic [16:0]       left_grad,
	output logic [16:0]       right_grad,
	output logic [1:0]        left_from,
	output logic [1:0]        left_to,
	output logic [1:0]        right_from,
	output logic [1:0]        right_to,
	output logic              last
);
	import tsew_pkg::*;

	// configuration
	logic [11:0] width_q, height_q;
	logic [15:0] near_q;

	// triangle state
	logic               active_q;
	logic [1:0]         ord_q [3];
	logic [15:0]        mid_y_q;
	logic signed [31:0] slope_q [3];
	logic [16:0]        gstep_q [3];
	logic [16:0]        gacc_q [3];
	logic signed [31:0] xacc_q [3];
	logic               b_left_q;
	logic [11:0]        cur_row_q, end_row_q;

	// sorted vertices held during a load
	logic [15:0] sax_q, say_q, sbx_q, sby_q, scx_q, scy_q;
	logic [2:0]  job_q;          // 0..5: slope AB, AC, BC, recip AB, AC, BC
	logic [1:0]  job_idx;        // edge that the current job writes
	logic        neg_q;
	logic signed [33:0] prod1_s1, prod2_s1;

	state_t state_q, state_d;

	div_req_t dreq;
	div_rsp_t drsp;

	tsew_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	logic in_fire, out_fire, busy;
	assign busy      = (state_q != ST_IDLE);
	assign in_stall  = busy || out_valid;
	assign in_fire   = in_valid && !in_stall;
	assign out_fire  = out_valid && !out_stall;
	assign cfg_ready = 1'b1;
	assign job_idx   = (job_q < 3'd3) ? job_q[1:0] : 2'(job_q - 3'd3);

	// accept checks and stable sort
	logic [15:0] px [3], py [3];
	logic signed [15:0] pz [3];
	logic [15:0] xmax, ymax;
	logic        reject;
	logic [1:0]  o0, o1, o2, t;
	always_comb begin
		px[0] = ax; px[1] = bx; px[2] = cx;
		py[0] = ay; py[1] = by_coord; py[2] = cy;
		pz[0] = az; pz[1] = bz; pz[2] = cz;
		xmax = {width_q, 4'd0};
		ymax = {height_q, 4'd0};
		reject = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (px[i] > xmax || py[i] > ymax) reject = 1'b1;
			if ($signed({pz[i][15], pz[i]}) <= $signed({1'b0, near_q})) reject = 1'b1;
		end
		t  = 2'd0;
		o0 = 2'd0; o1 = 2'd1; o2 = 2'd2;
		if (py[o0] > py[o1]) begin t = o0; o0 = o1; o1 = t; end
		if (py[o1] > py[o2]) begin t = o1; o1 = o2; o2 = t; end
		if (py[o0] > py[o1]) begin t = o0; o0 = o1; o1 = t; end
	end

	// shared divider operand selection
	logic signed [16:0] dx_sel;
	logic [16:0]        dy_sel;
	logic [16:0]        mag;
	always_comb begin
		case (job_q)
			3'd0, 3'd3: begin
				dx_sel = $signed({1'b0, sbx_q}) - $signed({1'b0, sax_q});
				dy_sel = {1'b0, sby_q} - {1'b0, say_q};
			end
			3'd1, 3'd4: begin
				dx_sel = $signed({1'b0, scx_q}) - $signed({1'b0, sax_q});
				dy_sel = {1'b0, scy_q} - {1'b0, say_q};
			end
			default: begin
				dx_sel = $signed({1'b0, scx_q}) - $signed({1'b0, sbx_q});
				dy_sel = {1'b0, scy_q} - {1'b0, sby_q};
			end
		endcase
		mag = dx_sel[16] ? 17'(-dx_sel) : 17'(dx_sel);
		dreq.start   = (state_q == ST_DIV_START);
		dreq.divisor = dy_sel;
		if (job_q < 3'd3) begin
			dreq.dividend = DIV_BITS'({mag, SLOPE_FRAC_BITS'(0)});
		end else begin
			dreq.dividend = DIV_BITS'(1) << (16 + COORD_FRAC_BITS);
		end
	end

	// divider result post-processing
	logic signed [31:0] slope_res;
	logic [16:0]        recip_res;
	always_comb begin
		if (dy_sel == '0) begin
			slope_res = '0;
		end else if (neg_q) begin
			slope_res = (drsp.quotient > DIV_BITS'(33'h0_8000_0000))
				? 32'sh8000_0000 : 32'(-$signed({1'b0, drsp.quotient[31:0]}));
		end else begin
			slope_res = (drsp.quotient > DIV_BITS'(32'h7FFF_FFFF))
				? 32'sh7FFF_FFFF : $signed(drsp.quotient[31:0]);
		end
		if (dy_sel == '0 || drsp.quotient > DIV_BITS'(GRAD_ONE)) begin
			recip_res = 17'(GRAD_ONE);
		end else begin
			recip_res = drsp.quotient[16:0];
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (in_fire && !func && !reject) state_d = ST_DIV_START;
			ST_DIV_START: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT:  if (drsp.done) state_d = (job_q == 3'd5) ? ST_AREA : ST_DIV_START;
			ST_AREA:      state_d = ST_FINISH;
			ST_FINISH:    state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// span selection for a step
	logic        upper, is_last;
	logic [1:0]  le, re, lf, lt, rf, rt;
	always_comb begin
		is_last = ({1'b0, cur_row_q} + 13'd1) >= {1'b0, end_row_q};
		upper   = ({4'd0, cur_row_q} + 16'd1) << COORD_FRAC_BITS < {4'd0, mid_y_q};
		if (upper) begin
			if (b_left_q) begin
				le = EDGE_AB; re = EDGE_AC; lf = 2'd0; lt = 2'd1; rf = 2'd0; rt = 2'd2;
			end else begin
				le = EDGE_AC; re = EDGE_AB; lf = 2'd0; lt = 2'd2; rf = 2'd0; rt = 2'd1;
			end
		end else begin
			if (b_left_q) begin
				le = EDGE_BC; re = EDGE_AC; lf = 2'd1; lt = 2'd2; rf = 2'd0; rt = 2'd2;
			end else begin
				le = EDGE_AC; re = EDGE_BC; lf = 2'd0; lt = 2'd2; rf = 2'd1; rt = 2'd2;
			end
		end
	end

	logic [17:0] gsum [3];
	always_comb begin
		for (int e = 0; e < 3; e++) begin
			gsum[e] = {1'b0, gacc_q[e]} + {1'b0, gstep_q[e]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			width_q    <= 12'd640;
			height_q   <= 12'd480;
			near_q     <= 16'd32;
			active_q   <= 1'b0;
			out_valid  <= 1'b0;
			job_q      <= '0;
			neg_q      <= 1'b0;
			mid_y_q    <= '0;
			b_left_q   <= 1'b0;
			cur_row_q  <= '0;
			end_row_q  <= '0;
			span_valid <= 1'b0;
			row        <= '0;
			left_x     <= '0;
			right_x    <= '0;
			left_grad  <= '0;
			right_grad <= '0;
			left_from  <= '0;
			left_to    <= '0;
			right_from <= '0;
			right_to   <= '0;
			last       <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				ord_q[i]   <= '0;
				slope_q[i] <= '0;
				gstep_q[i] <= '0;
				gacc_q[i]  <= '0;
				xacc_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_WIDTH:  width_q  <= cfg_data[11:0];
					CFG_HEIGHT: height_q <= cfg_data[11:0];
					CFG_NEAR:   near_q   <= cfg_data;
					default:    ;
				endcase
			end
			if (out_fire) out_valid <= 1'b0;

			if (in_fire && !func) begin
				// any load ends the current triangle
				active_q <= 1'b0;
				job_q    <= '0;
				if (!reject) begin
					ord_q[0] <= o0; ord_q[1] <= o1; ord_q[2] <= o2;
					mid_y_q  <= py[o1];
				end
			end else if (in_fire) begin
				out_valid  <= 1'b1;
				span_valid <= active_q;
				if (!active_q) begin
					row <= '0; left_x <= '0; right_x <= '0;
					left_grad <= '0; right_grad <= '0;
					left_from <= '0; left_to <= '0; right_from <= '0; right_to <= '0;
					last <= 1'b0;
				end else begin
					row        <= cur_row_q;
					left_x     <= trunc_x(xacc_q[le]);
					right_x    <= trunc_x(xacc_q[re]);
					left_grad  <= gacc_q[le];
					right_grad <= gacc_q[re];
					left_from  <= ord_q[lf];
					left_to    <= ord_q[lt];
					right_from <= ord_q[rf];
					right_to   <= ord_q[rt];
					last       <= is_last;
					for (int e = 0; e < 3; e++) begin
						if (e == 1 || (e == 0 && upper) || (e == 2 && !upper)) begin
							gacc_q[e] <= (gsum[e] > 18'(GRAD_ONE)) ? 17'(GRAD_ONE) : gsum[e][16:0];
							xacc_q[e] <= sat32(34'(xacc_q[e]) + 34'(slope_q[e]));
						end
					end
					cur_row_q <= cur_row_q + 12'd1;
					if (is_last) active_q <= 1'b0;
				end
			end

			if (state_q == ST_DIV_START) neg_q <= dx_sel[16];
			if (state_q == ST_DIV_WAIT && drsp.done) begin
				if (job_q < 3'd3) slope_q[job_idx] <= slope_res;
				else gstep_q[job_idx] <= recip_res;
				job_q <= job_q + 3'd1;
			end
			if (state_q == ST_FINISH) begin
				for (int e = 0; e < 3; e++) gacc_q[e] <= '0;
				// start x moves from Q12.4 to Q16.16: A for edges AB and AC, B for BC
				xacc_q[0] <= $signed({4'd0, sax_q, 12'd0});
				xacc_q[1] <= $signed({4'd0, sax_q, 12'd0});
				xacc_q[2] <= $signed({4'd0, sbx_q, 12'd0});
				b_left_q  <= (prod1_s1 - prod2_s1) < 0;
				cur_row_q <= say_q[15:4];
				end_row_q <= scy_q[15:4];
				active_q  <= say_q[15:4] < scy_q[15:4];
			end
		end
	end

	// sorted vertex capture and area products
	always_ff @(posedge clk) begin
		if (in_fire && !func) begin
			sax_q <= px[o0]; say_q <= py[o0];
			sbx_q <= px[o1]; sby_q <= py[o1];
			scx_q <= px[o2]; scy_q <= py[o2];
		end
		if (state_q == ST_AREA) begin
			prod1_s1 <= 34'(($signed({1'b0, sbx_q}) - $signed({1'b0, sax_q}))
				* ($signed({1'b0, scy_q}) - $signed({1'b0, say_q})));
			prod2_s1 <= 34'(($signed({1'b0, scx_q}) - $signed({1'b0, sax_q}))
				* ($signed({1'b0, sby_q}) - $signed({1'b0, say_q})));
		end
	end

endmodule

`default_nettype wire
